[sv/uer_pkg.sv]
// Package for the ultrasonic echo ranging timer: request and result types,
// phase codes, register indexes, reset values and the divide-by-58 constants.
// No dependencies.
package uer_pkg;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} uer_in_t;

	typedef struct packed {
		logic        trigger_level;
		logic        busy_res;
		logic        done_res;
		logic [10:0] range_cm;
		logic [1:0]  status;
	} uer_out_t;

	localparam int CfgDataW = 16;
	localparam int CfgIdxW  = 3;

	localparam logic [CfgIdxW-1:0] REG_SETTLE_LOW  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_TRIGGER_HI  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_TIMEOUT     = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ECHO_MIN    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ECHO_MAX    = 3'd4;

	localparam logic [7:0]  RST_SETTLE_LOW = 8'd2;
	localparam logic [7:0]  RST_TRIGGER_HI = 8'd10;
	localparam logic [15:0] RST_TIMEOUT    = 16'd30000;
	localparam logic [15:0] RST_ECHO_MIN   = 16'd116;
	localparam logic [15:0] RST_ECHO_MAX   = 16'd23200;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_SETTLE = 2'd1;
	localparam logic [1:0] PH_HIGH   = 2'd2;
	localparam logic [1:0] PH_WAIT   = 2'd3;

	localparam logic [1:0] ST_VALID   = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	// w / 58 == (w * ceil(2^22 / 58)) >> 22, exact for any 16-bit w
	localparam int          DivShift = 22;
	localparam logic [16:0] DIV58_MUL = 17'd72316;

	localparam logic [15:0] CNT_MAX = 16'hFFFF;

endpackage

[sv/ultrasonic_echo_ranging.sv]
// Ultrasonic echo ranging timer: one request per microsecond tick, one result each.
// The result of a request is registered and appears in the cycle after it is accepted.
// Throughput: one request per cycle; the input stalls only while a result waits.
// Reset: phase idle, counters and echo tracking cleared, registers at defaults.
// Depends on uer_pkg.
module ultrasonic_echo_ranging (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [uer_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [uer_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  uer_pkg::uer_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output uer_pkg::uer_out_t             out_data
);
	import uer_pkg::*;

	logic [7:0]  settle_low_q;
	logic [7:0]  trigger_high_q;
	logic [15:0] timeout_q;
	logic [15:0] echo_min_q;
	logic [15:0] echo_max_q;

	logic [1:0]  phase_q, phase_n;
	logic [15:0] count_q, count_n;
	logic        active_q, active_n;
	logic        ready_q, ready_n;
	logic        prev_q;
	logic [15:0] width_q, width_n;

	logic        out_valid_q;
	uer_out_t    out_data_s1;
	uer_out_t    res;

	logic        accept;
	logic [15:0] count_inc;
	logic [32:0] prod;

	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_s1;

	assign count_inc = (count_q < CNT_MAX) ? count_q + 16'd1 : count_q;
	assign prod      = {17'd0, width_n} * {16'd0, DIV58_MUL};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_low_q   <= RST_SETTLE_LOW;
			trigger_high_q <= RST_TRIGGER_HI;
			timeout_q      <= RST_TIMEOUT;
			echo_min_q     <= RST_ECHO_MIN;
			echo_max_q     <= RST_ECHO_MAX;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SETTLE_LOW: settle_low_q   <= cfg_data[7:0];
				REG_TRIGGER_HI: trigger_high_q <= cfg_data[7:0];
				REG_TIMEOUT:    timeout_q      <= cfg_data;
				REG_ECHO_MIN:   echo_min_q     <= cfg_data;
				REG_ECHO_MAX:   echo_max_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		width_n  = (active_q && width_q < CNT_MAX) ? width_q + 16'd1 : width_q;
		active_n = active_q;
		ready_n  = ready_q;
		if (in_data.echo_level && !prev_q) begin
			active_n = 1'b1;
			ready_n  = 1'b0;
			width_n  = '0;
		end else if (!in_data.echo_level && prev_q && active_q) begin
			active_n = 1'b0;
			ready_n  = 1'b1;
		end

		phase_n = phase_q;
		count_n = count_q;
		res     = '0;

		case (phase_q)
			PH_IDLE: begin
				if (in_data.start_req) begin
					active_n = 1'b0;
					ready_n  = 1'b0;
					count_n  = 16'd1;
					phase_n  = (settle_low_q == 8'd0) ? PH_HIGH : PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				if (count_q >= {8'd0, settle_low_q}) begin
					phase_n = PH_HIGH;
					count_n = 16'd1;
				end else begin
					count_n = count_inc;
				end
			end
			PH_HIGH: begin
				if (count_q >= {8'd0, trigger_high_q}) begin
					phase_n = PH_WAIT;
					count_n = '0;
				end else begin
					count_n = count_inc;
				end
			end
			PH_WAIT: begin
				if (ready_n) begin
					res.done_res = 1'b1;
					if (width_n < echo_min_q || width_n > echo_max_q)
						res.status = ST_RANGE;
					else
						res.range_cm = prod[DivShift+10:DivShift];
				end else begin
					count_n = count_inc;
					if (count_inc > timeout_q) begin
						res.done_res = 1'b1;
						res.status   = ST_TIMEOUT;
					end
				end
				if (res.done_res) begin
					phase_n = PH_IDLE;
					count_n = '0;
				end
			end
			default: ;
		endcase

		res.trigger_level = (phase_n == PH_HIGH);
		res.busy_res      = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			active_q    <= 1'b0;
			ready_q     <= 1'b0;
			prev_q      <= 1'b0;
			width_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q  <= phase_n;
				count_q  <= count_n;
				active_q <= active_n;
				ready_q  <= ready_n;
				prev_q   <= in_data.echo_level;
				width_q  <= width_n;
			end
			if (accept)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_data_s1 <= res;
	end

endmodule
